// ----- design/knob_shift_accelerator_assert.svh -----
// Assertion helpers used by the checker file.
`ifndef KNOB_SHIFT_ACCELERATOR_ASSERT_SVH
`define KNOB_SHIFT_ACCELERATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define KSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ksa check failed");

// next-cycle implication, disabled while reset is asserted
`define KSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ksa check failed");

`endif

// ----- design/ksa_pkg.sv -----
package ksa_pkg;

    // knob codes (func / target)
    localparam logic [1:0] FUNC_SHIFT_A = 2'd0;
    localparam logic [1:0] FUNC_SHIFT_B = 2'd1;
    localparam logic [1:0] FUNC_TRIG    = 2'd2;
    localparam logic [1:0] FUNC_TIME    = 2'd3;

    // direction codes
    localparam logic [1:0] DIR_NONE  = 2'b00;
    localparam logic [1:0] DIR_RIGHT = 2'b01;
    localparam logic [1:0] DIR_LEFT2 = 2'b10;
    localparam logic [1:0] DIR_LEFT  = 2'b11;

    // config register indexes
    localparam logic [2:0] REG_SHIFT_ZERO = 3'd0;
    localparam logic [2:0] REG_SHIFT_MIN  = 3'd1;
    localparam logic [2:0] REG_SHIFT_MAX  = 3'd2;
    localparam logic [2:0] REG_TRIG_ZERO  = 3'd3;
    localparam logic [2:0] REG_TRIG_MIN   = 3'd4;
    localparam logic [2:0] REG_TRIG_MAX   = 3'd5;
    localparam logic [2:0] REG_STEP_SIZE  = 3'd6;
    localparam logic [2:0] REG_HOLD_MS    = 3'd7;

    // config reset values
    localparam logic [15:0] RST_SHIFT_ZERO = 16'd500;
    localparam logic [15:0] RST_SHIFT_MIN  = 16'd20;
    localparam logic [15:0] RST_SHIFT_MAX  = 16'd980;
    localparam logic [15:0] RST_TRIG_ZERO  = 16'd500;
    localparam logic [15:0] RST_TRIG_MIN   = 16'd20;
    localparam logic [15:0] RST_TRIG_MAX   = 16'd980;
    localparam logic [7:0]  RST_STEP_SIZE  = 8'd2;
    localparam logic [15:0] RST_HOLD_MS    = 16'd500;

    // speed thresholds in ms
    localparam logic [31:0] SPEED_T1 = 32'd75;
    localparam logic [31:0] SPEED_T2 = 32'd50;
    localparam logic [31:0] SPEED_T3 = 32'd25;

    // operands picked for the knob being handled
    typedef struct packed {
        logic              is_time;
        logic [1:0]        dir;
        logic [15:0]       old;
        logic [15:0]       zero;
        logic [15:0]       lo;
        logic [15:0]       hi;
        logic [7:0]        step;
        logic [15:0]       hold;
        logic [31:0]       now;
        logic [31:0]       last;
        logic [31:0]       lock_time;
        logic              lock_valid;
    } t_sel;

    // outcome of one detent
    typedef struct packed {
        logic [16:0] value;
        logic        applied;
        logic [2:0]  factor;
        logic        at_zero;
        logic        expire;
    } t_calc;

endpackage

// ----- design/ksa_calc.sv -----
module ksa_calc import ksa_pkg::*; (
    input  t_sel  i_sel,
    output t_calc o_res
);

    logic [31:0]        w_elapsed;
    logic [31:0]        w_lock_age;
    logic [2:0]         w_factor;
    logic [10:0]        w_mag;
    logic signed [12:0] w_delta;
    logic signed [18:0] w_old19;
    logic signed [18:0] w_zero19;
    logic signed [18:0] w_lo19;
    logic signed [18:0] w_hi19;
    logic signed [18:0] w_vsum;
    logic signed [18:0] w_vsnap;
    logic signed [18:0] w_vclamp;
    logic signed [4:0]  w_tstep;
    logic signed [15:0] w_told;
    logic signed [17:0] w_tsum;
    logic signed [15:0] w_tsat;
    logic signed [15:0] w_tval;
    logic               w_at_zero;
    logic               w_expire;

    assign w_elapsed  = i_sel.now - i_sel.last;
    assign w_lock_age = i_sel.now - i_sel.lock_time;

    always_comb begin
        if (w_elapsed > SPEED_T1) begin
            w_factor = 3'd1;
        end else if (w_elapsed > SPEED_T2) begin
            w_factor = 3'd2;
        end else if (w_elapsed > SPEED_T3) begin
            w_factor = 3'd3;
        end else begin
            w_factor = 3'd4;
        end
    end

    // vertical shift / trigger level path
    assign w_mag = 11'(i_sel.step) * 11'(w_factor);

    always_comb begin
        case (i_sel.dir)
            DIR_RIGHT: w_delta = $signed({2'b00, w_mag});
            DIR_LEFT:  w_delta = -$signed({2'b00, w_mag});
            DIR_LEFT2: w_delta = -$signed({1'b0, w_mag, 1'b0});
            default:   w_delta = 13'sd0;
        endcase
    end

    assign w_old19  = $signed({3'b000, i_sel.old});
    assign w_zero19 = $signed({3'b000, i_sel.zero});
    assign w_lo19   = $signed({3'b000, i_sel.lo});
    assign w_hi19   = $signed({3'b000, i_sel.hi});
    assign w_vsum   = w_old19 + 19'(w_delta);

    always_comb begin
        if ((w_old19 > w_zero19 && w_vsum < w_zero19) ||
            (w_old19 < w_zero19 && w_vsum > w_zero19)) begin
            w_vsnap = w_zero19;
        end else begin
            w_vsnap = w_vsum;
        end
        // max wins when min > max
        w_vclamp = w_vsnap;
        if (w_vclamp < w_lo19) begin
            w_vclamp = w_lo19;
        end
        if (w_vclamp > w_hi19) begin
            w_vclamp = w_hi19;
        end
    end

    // time shift path
    always_comb begin
        case (i_sel.dir)
            DIR_RIGHT: w_tstep = $signed({2'b00, w_factor});
            DIR_LEFT:  w_tstep = -$signed({2'b00, w_factor});
            DIR_LEFT2: w_tstep = -$signed({1'b0, w_factor, 1'b0});
            default:   w_tstep = 5'sd1;
        endcase
    end

    assign w_told = $signed(i_sel.old);
    assign w_tsum = 18'(w_told) + 18'(w_tstep);

    always_comb begin
        if (w_tsum > 18'sd32767) begin
            w_tsat = 16'sh7fff;
        end else if (w_tsum < -18'sd32768) begin
            w_tsat = 16'sh8000;
        end else begin
            w_tsat = w_tsum[15:0];
        end
        if ((w_told > 16'sd0 && w_tsat < 16'sd0) || (w_told < 16'sd0 && w_tsat > 16'sd0)) begin
            w_tval = 16'sd0;
        end else begin
            w_tval = w_tsat;
        end
    end

    // zero lock
    assign w_at_zero = i_sel.is_time ? (w_tval == 16'sd0) : (w_vclamp == w_zero19);
    assign w_expire  = i_sel.lock_valid && !w_at_zero && (w_lock_age > 32'(i_sel.hold));

    assign o_res.value   = i_sel.is_time ? {w_tval[15], w_tval} : w_vclamp[16:0];
    assign o_res.applied = w_at_zero || !i_sel.lock_valid || w_expire;
    assign o_res.factor  = w_factor;
    assign o_res.at_zero = w_at_zero;
    assign o_res.expire  = w_expire;

endmodule

// ----- design/knob_shift_accelerator.sv -----
// Knob acceleration with a zero detent.
// Input stream: one word per knob detent. tuser = func (knob), tdata = direction,
// trigger source and millisecond timestamp. Output stream: one word per detent
// with the target, the value after the step, whether it was stored and the
// speed factor. Config: write i_cfg_we with a register index and data while
// the block is idle; there is no read-back.
// Datapath: an accepted input word is held in the input register, then its
// result word in the result register. Throughput: one word per cycle while
// the receiver is not stalling; the single pass from the input register to
// the result register also updates the knob state, so the next word sees it
// with no bubble.
// Reset (synchronous, active low) restores the register defaults, puts the
// shifts and trigger levels at their zero points, clears time shift, the
// knob timestamps and all locks, and empties both pipeline registers.
// When the receiver stalls, the result is held; one more word is taken into
// the input register, then o_s_tready drops until the output drains.
module knob_shift_accelerator import ksa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // direction[1:0], trig_source[3:2], now_ms[35:4], 0
    input  logic [1:0]  i_s_tuser,  // func[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // new_value[16:0], applied[17], speed_factor[20:18], 0
    output logic [1:0]  o_m_tuser,  // target[1:0]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    // config
    logic [15:0] r_shift_zero, r_shift_min, r_shift_max;
    logic [15:0] r_trig_zero, r_trig_min, r_trig_max;
    logic [7:0]  r_step_size;
    logic [15:0] r_hold_ms;

    // knob state
    logic [31:0] r_last [4];
    logic [15:0] r_chan [2];
    logic [15:0] r_trig [3];
    logic [15:0] r_time_shift;
    logic [31:0] r_zlock_time [3];
    logic [2:0]  r_zlock_valid;
    logic [31:0] r_tlock_time;
    logic        r_tlock_valid;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_func;
    logic [1:0]  r_dir;
    logic [1:0]  r_src;
    logic [31:0] r_now;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_target;
    logic [16:0] r_value;
    logic        r_applied;
    logic [2:0]  r_factor;

    logic        w_fire;
    logic [1:0]  w_tidx;
    logic [1:0]  w_lidx;
    logic        w_is_time;
    logic        w_is_trig;
    t_sel        w_sel;
    t_calc       w_res;

    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;

    // trigger source 3 behaves as source 2
    assign w_tidx    = (r_src == 2'd3) ? 2'd2 : r_src;
    assign w_is_time = (r_func == FUNC_TIME);
    assign w_is_trig = (r_func == FUNC_TRIG);
    // channel A / source 0 and channel B / source 1 share a lock entry
    assign w_lidx    = w_is_trig ? w_tidx : r_func;

    always_comb begin
        w_sel.is_time = w_is_time;
        w_sel.dir     = r_dir;
        w_sel.step    = r_step_size;
        w_sel.hold    = r_hold_ms;
        w_sel.now     = r_now;
        w_sel.last    = r_last[r_func];
        if (w_is_time) begin
            w_sel.old        = r_time_shift;
            w_sel.zero       = r_shift_zero;
            w_sel.lo         = r_shift_min;
            w_sel.hi         = r_shift_max;
            w_sel.lock_time  = r_tlock_time;
            w_sel.lock_valid = r_tlock_valid;
        end else if (w_is_trig) begin
            w_sel.old        = r_trig[w_tidx];
            w_sel.zero       = r_trig_zero;
            w_sel.lo         = r_trig_min;
            w_sel.hi         = r_trig_max;
            w_sel.lock_time  = r_zlock_time[w_lidx];
            w_sel.lock_valid = r_zlock_valid[w_lidx];
        end else begin
            w_sel.old        = r_chan[r_func[0]];
            w_sel.zero       = r_shift_zero;
            w_sel.lo         = r_shift_min;
            w_sel.hi         = r_shift_max;
            w_sel.lock_time  = r_zlock_time[w_lidx];
            w_sel.lock_valid = r_zlock_valid[w_lidx];
        end
    end

    ksa_calc u_calc (
        .i_sel (w_sel),
        .o_res (w_res)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_zero <= RST_SHIFT_ZERO;
            r_shift_min  <= RST_SHIFT_MIN;
            r_shift_max  <= RST_SHIFT_MAX;
            r_trig_zero  <= RST_TRIG_ZERO;
            r_trig_min   <= RST_TRIG_MIN;
            r_trig_max   <= RST_TRIG_MAX;
            r_step_size  <= RST_STEP_SIZE;
            r_hold_ms    <= RST_HOLD_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SHIFT_ZERO: r_shift_zero <= i_cfg_data;
                REG_SHIFT_MIN:  r_shift_min  <= i_cfg_data;
                REG_SHIFT_MAX:  r_shift_max  <= i_cfg_data;
                REG_TRIG_ZERO:  r_trig_zero  <= i_cfg_data;
                REG_TRIG_MIN:   r_trig_min   <= i_cfg_data;
                REG_TRIG_MAX:   r_trig_max   <= i_cfg_data;
                REG_STEP_SIZE:  r_step_size  <= i_cfg_data[7:0];
                REG_HOLD_MS:    r_hold_ms    <= i_cfg_data;
                default:        r_hold_ms    <= r_hold_ms;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_func <= i_s_tuser;
            r_dir  <= i_s_tdata[1:0];
            r_src  <= i_s_tdata[3:2];
            r_now  <= i_s_tdata[35:4];
        end
    end

    // knob state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_last[k] <= '0;
            end
            for (int k = 0; k < 2; k++) begin
                r_chan[k] <= RST_SHIFT_ZERO;
            end
            for (int k = 0; k < 3; k++) begin
                r_trig[k]       <= RST_TRIG_ZERO;
                r_zlock_time[k] <= '0;
            end
            r_zlock_valid <= '0;
            r_time_shift  <= '0;
            r_tlock_time  <= '0;
            r_tlock_valid <= 1'b0;
        end else if (w_fire) begin
            r_last[r_func] <= r_now;
            if (w_res.applied) begin
                if (w_is_time) begin
                    r_time_shift <= w_res.value[15:0];
                end else if (w_is_trig) begin
                    r_trig[w_tidx] <= w_res.value[15:0];
                end else begin
                    r_chan[r_func[0]] <= w_res.value[15:0];
                end
            end
            if (w_is_time) begin
                if (w_res.at_zero) begin
                    r_tlock_time  <= r_now;
                    r_tlock_valid <= 1'b1;
                end else if (w_res.expire) begin
                    r_tlock_time  <= '0;
                    r_tlock_valid <= 1'b0;
                end
            end else begin
                if (w_res.at_zero) begin
                    r_zlock_time[w_lidx]  <= r_now;
                    r_zlock_valid[w_lidx] <= 1'b1;
                end else if (w_res.expire) begin
                    r_zlock_time[w_lidx]  <= '0;
                    r_zlock_valid[w_lidx] <= 1'b0;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_target  <= r_func;
            r_value   <= w_res.value;
            r_applied <= w_res.applied;
            r_factor  <= w_res.factor;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_factor, r_applied, r_value};
    assign o_m_tuser  = r_target;

endmodule

// ----- design/ksa_checker.sv -----
`include "knob_shift_accelerator_assert.svh"

module ksa_checker import ksa_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // a held result word stays put
    `KSA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // input side only backs up behind a stalled output word
    `KSA_ASSERT_IMP(a_ready_stall, i_clk, i_rst_n, !o_s_tready, o_m_tvalid && !i_m_tready)

    // factor is always 1 to 4
    `KSA_ASSERT_IMP(a_factor_rng, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[20:18] != 3'd0 && o_m_tdata[20:18] <= 3'd4)

    // time shift result is a sign-extended 16-bit value, others are unsigned 16-bit
    `KSA_ASSERT_IMP(a_value_ext, i_clk, i_rst_n, o_m_tvalid, (o_m_tuser == FUNC_TIME) ? (o_m_tdata[16] == o_m_tdata[15]) : (o_m_tdata[16] == 1'b0))

endmodule

bind knob_shift_accelerator ksa_checker u_ksa_checker (.*);

// ----- bench/testbench.sv -----
module testbench;
    import ksa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LOCK_TIME   = 3;      // lock entry used by the time shift knob
    localparam logic [1:0] SRC_LAST  = 2'd2;
    localparam logic [1:0] SRC_SPARE = 2'd3;

    typedef logic [15:0] reg_set_t [8];

    typedef struct {
        logic [1:0]  target;
        logic [16:0] value;
        logic        applied;
        logic [2:0]  factor;
    } detent_result_t;

    // Tracks knob state and queues the result each accepted detent should produce.
    class knob_state_tracker;
        logic [15:0] knob_reg [8];
        logic [31:0] turn_stamp [4];
        int          chan_level [2];
        int          trig_level [3];
        int          time_offset;
        logic [31:0] lock_stamp [4];
        bit          lock_armed [4];
        detent_result_t due_results [$];
        int errors;
        int checked;
        int noted;

        function new();
            knob_reg[REG_SHIFT_ZERO] = RST_SHIFT_ZERO;
            knob_reg[REG_SHIFT_MIN]  = RST_SHIFT_MIN;
            knob_reg[REG_SHIFT_MAX]  = RST_SHIFT_MAX;
            knob_reg[REG_TRIG_ZERO]  = RST_TRIG_ZERO;
            knob_reg[REG_TRIG_MIN]   = RST_TRIG_MIN;
            knob_reg[REG_TRIG_MAX]   = RST_TRIG_MAX;
            knob_reg[REG_STEP_SIZE]  = {8'd0, RST_STEP_SIZE};
            knob_reg[REG_HOLD_MS]    = RST_HOLD_MS;
            for (int i = 0; i < 4; i++) begin
                turn_stamp[i] = '0;
                lock_stamp[i] = '0;
                lock_armed[i] = 1'b0;
            end
            chan_level = '{int'(RST_SHIFT_ZERO), int'(RST_SHIFT_ZERO)};
            trig_level = '{int'(RST_TRIG_ZERO), int'(RST_TRIG_ZERO), int'(RST_TRIG_ZERO)};
            time_offset = 0;
            errors = 0;
            checked = 0;
            noted = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            knob_reg[idx] = (idx == REG_STEP_SIZE) ? {8'd0, val[7:0]} : val;
        endfunction

        // a step that jumps over the detent point stops on it
        function int snap_to_detent(int oldv, int newv, int zero);
            if ((oldv > zero && newv < zero) || (oldv < zero && newv > zero))
                return zero;
            return newv;
        endfunction

        function bit lock_gate(int k, bit at_zero, logic [31:0] now);
            logic [31:0] held;
            if (at_zero) begin
                lock_stamp[k] = now;
                lock_armed[k] = 1'b1;
                return 1'b1;
            end
            if (!lock_armed[k])
                return 1'b1;
            held = now - lock_stamp[k];
            if (held > {16'd0, knob_reg[REG_HOLD_MS]}) begin
                lock_armed[k] = 1'b0;
                lock_stamp[k] = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_detent(logic [1:0] knob, logic [1:0] dcode, logic [1:0] src,
                                  logic [31:0] now);
            detent_result_t r;
            logic [31:0] elapsed;
            int dir, oldv, v, zero, lo, hi, slot, step;
            bit ok;
            elapsed = now - turn_stamp[knob];
            r.factor = (elapsed > SPEED_T1) ? 3'd1 : (elapsed > SPEED_T2) ? 3'd2 :
                       (elapsed > SPEED_T3) ? 3'd3 : 3'd4;
            turn_stamp[knob] = now;
            dir = $signed(dcode);
            if (knob != FUNC_TIME) begin
                if (knob == FUNC_TRIG) begin
                    slot = (src == SRC_SPARE) ? int'(SRC_LAST) : int'(src);
                    oldv = trig_level[slot];
                    zero = int'(knob_reg[REG_TRIG_ZERO]);
                    lo   = int'(knob_reg[REG_TRIG_MIN]);
                    hi   = int'(knob_reg[REG_TRIG_MAX]);
                end else begin
                    slot = int'(knob);
                    oldv = chan_level[slot];
                    zero = int'(knob_reg[REG_SHIFT_ZERO]);
                    lo   = int'(knob_reg[REG_SHIFT_MIN]);
                    hi   = int'(knob_reg[REG_SHIFT_MAX]);
                end
                v = oldv + dir * int'(knob_reg[REG_STEP_SIZE]) * int'(r.factor);
                v = snap_to_detent(oldv, v, zero);
                if (v < lo) v = lo;
                if (v > hi) v = hi;    // max wins over min
                ok = lock_gate(slot, v == zero, now);
                if (ok) begin
                    if (knob == FUNC_TRIG) trig_level[slot] = v;
                    else chan_level[slot] = v;
                end
            end else begin
                step = (dir == 0) ? 1 : dir * int'(r.factor);
                v = time_offset + step;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                v = snap_to_detent(time_offset, v, 0);
                ok = lock_gate(LOCK_TIME, v == 0, now);
                if (ok) time_offset = v;
            end
            r.target  = knob;
            r.value   = v[16:0];
            r.applied = ok;
            due_results.push_back(r);
            noted++;
        endfunction

        function void compare_result(logic [1:0] tgt, logic [16:0] val, logic app,
                                     logic [2:0] fac);
            detent_result_t e;
            if (due_results.size() == 0) begin
                $error("unexpected word: target %0d value 0x%0h", tgt, val);
                errors++;
                return;
            end
            e = due_results.pop_front();
            checked++;
            if (tgt !== e.target) begin
                $error("target: expected %0d, actual %0d", e.target, tgt);
                errors++;
            end
            if (val !== e.value) begin
                $error("new_value: expected 0x%0h, actual 0x%0h", e.value, val);
                errors++;
            end
            if (app !== e.applied) begin
                $error("applied: expected %0b, actual %0b", e.applied, app);
                errors++;
            end
            if (fac !== e.factor) begin
                $error("speed_factor: expected %0d, actual %0d", e.factor, fac);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    knob_shift_accelerator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    knob_state_tracker tracker = new();
    int          tx_idle_pct = 25;
    int          rx_idle_pct = 56;
    int          cycles = 0;
    logic [31:0] stamp = 32'd1000;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.compare_result(o_m_tuser, o_m_tdata[16:0], o_m_tdata[17],
                                   o_m_tdata[20:18]);

    // tvalid is left high after a word goes in, so back-to-back words need no toggle
    task automatic send_detent(input logic [1:0] knob, input logic [1:0] dcode,
                               input logic [1:0] src, input logic [31:0] now);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= knob;
        i_s_tdata  <= {4'd0, now, src, dcode};
        do @(posedge i_clk); while (!o_s_tready);
        tracker.take_detent(knob, dcode, src, now);
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_registers(input reg_set_t vals);
        settle();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            tracker.set_reg(3'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [1:0] pick_dir();
        int r;
        r = $urandom_range(99);
        if (r < 45) return DIR_RIGHT;
        if (r < 90) return DIR_LEFT;
        if (r < 95) return DIR_NONE;
        return DIR_LEFT2;
    endfunction

    // bursts on one knob so acceleration and zero crossings actually happen
    task automatic random_bursts(input int count);
        int sent;
        int run;
        int r;
        logic [1:0] knob, dcode, src;
        sent = 0;
        while (sent < count) begin
            knob  = 2'($urandom_range(3));
            src   = 2'($urandom_range(3));
            dcode = pick_dir();
            run   = $urandom_range(1, 12);
            for (int k = 0; k < run && sent < count; k++) begin
                r = $urandom_range(99);
                if (r < 8) dcode = 2'($urandom_range(3));
                else if (r < 22) dcode = (dcode == DIR_RIGHT) ? DIR_LEFT : DIR_RIGHT;
                r = $urandom_range(99);
                if (r < 3) stamp = $urandom();
                else if (r < 12) stamp = stamp + $urandom_range(100, 2000);
                else stamp = stamp + $urandom_range(0, 90);
                send_detent(knob, dcode, src, stamp);
                sent++;
            end
        end
    endtask

    initial begin
        reg_set_t regs;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        i_m_tready <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: speed bands, snap to detent, lock refuse and expiry,
        // shared lock, spare trigger source, zero and double-left directions
        send_detent(FUNC_SHIFT_A, DIR_RIGHT, 2'd0, 32'd1000);
        send_detent(FUNC_SHIFT_A, DIR_LEFT,  2'd0, 32'd1010);
        send_detent(FUNC_SHIFT_A, DIR_LEFT,  2'd0, 32'd1020);
        send_detent(FUNC_TRIG,    DIR_RIGHT, 2'd0, 32'd1030);
        send_detent(FUNC_SHIFT_A, DIR_RIGHT, 2'd0, 32'd1600);
        send_detent(FUNC_SHIFT_A, DIR_RIGHT, 2'd0, 32'd1660);
        send_detent(FUNC_SHIFT_A, DIR_RIGHT, 2'd0, 32'd1700);
        send_detent(FUNC_SHIFT_A, DIR_NONE,  2'd0, 32'd1701);
        send_detent(FUNC_SHIFT_A, DIR_LEFT2, 2'd0, 32'd1702);
        send_detent(FUNC_SHIFT_B, DIR_LEFT2, 2'd1, 32'd1800);
        send_detent(FUNC_TRIG,    DIR_RIGHT, SRC_SPARE, 32'd1900);
        send_detent(FUNC_TRIG,    DIR_LEFT,  2'd1, 32'd1905);
        send_detent(FUNC_TIME,    DIR_NONE,  2'd0, 32'd2000);
        send_detent(FUNC_TIME,    DIR_LEFT2, 2'd0, 32'd2010);
        send_detent(FUNC_TIME,    DIR_RIGHT, 2'd0, 32'd2020);
        send_detent(FUNC_TIME,    DIR_LEFT,  2'd3, 32'hFFFF_FFFF);
        send_detent(FUNC_SHIFT_A, DIR_RIGHT, 2'd2, 32'd0);
        stamp = 32'd5000;

        regs = '{16'd500, 16'd20, 16'd980, 16'd500, 16'd20, 16'd980, 16'd2, 16'd500};
        load_registers(regs);
        random_bursts(140);
        regs = '{16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd65535, 16'd255, 16'd0};
        load_registers(regs);
        random_bursts(140);

        tx_idle_pct = 56;
        rx_idle_pct = 25;
        // min above max on both value kinds
        regs = '{16'd300, 16'd900, 16'd100, 16'd40000, 16'd65000, 16'd30000, 16'd1,
                 16'd65535};
        load_registers(regs);
        random_bursts(140);
        regs = '{16'd1000, 16'd990, 16'd1010, 16'd2000, 16'd1990, 16'd2010, 16'd3, 16'd40};
        load_registers(regs);
        random_bursts(140);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        regs = '{16'd500, 16'd20, 16'd980, 16'd500, 16'd20, 16'd980, 16'd2, 16'd500};
        load_registers(regs);
        random_bursts(140);

        // short fast time shift walk right then double-left; zero hold so crossings pass
        regs = '{16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd65535, 16'd255, 16'd0};
        load_registers(regs);
        for (int k = 0; k < 20; k++) begin
            stamp = stamp + 32'd1;
            send_detent(FUNC_TIME, DIR_RIGHT, 2'd0, stamp);
        end
        for (int k = 0; k < 20; k++) begin
            stamp = stamp + 32'd1;
            send_detent(FUNC_TIME, DIR_LEFT2, 2'd0, stamp);
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d detents: directed cases, random knob bursts over five register sets",
                 tracker.noted);
        $display("and a fast time shift walk; %0d words compared", tracker.checked);
        if (tracker.errors == 0 && tracker.due_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- knob_shift_accelerator.f -----
+incdir+design
design/ksa_pkg.sv
design/ksa_calc.sv
design/knob_shift_accelerator.sv
design/ksa_checker.sv
bench/testbench.sv
